[rtl/bole_pkg.sv]
// ----------------------------------------------------------------------------
// bole_pkg: shared definitions for the bounded ordered list engine
// Operation codes, status codes and fixed field widths of the stream ports.
// ----------------------------------------------------------------------------
package bole_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int ITEM_BITS_DEF = 32;

	localparam int OP_W    = 4;
	localparam int POS_W   = 5;
	localparam int ITEM_W  = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 5;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 48;

	localparam logic [OP_W-1:0] OP_ADD_FIRST    = 4'd0;
	localparam logic [OP_W-1:0] OP_ADD_LAST     = 4'd1;
	localparam logic [OP_W-1:0] OP_INSERT_AFTER = 4'd2;
	localparam logic [OP_W-1:0] OP_PEEK_FIRST   = 4'd3;
	localparam logic [OP_W-1:0] OP_PEEK_LAST    = 4'd4;
	localparam logic [OP_W-1:0] OP_PEEK_AT      = 4'd5;
	localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 4'd6;
	localparam logic [OP_W-1:0] OP_REMOVE_LAST  = 4'd7;
	localparam logic [OP_W-1:0] OP_REMOVE_AT    = 4'd8;
	localparam logic [OP_W-1:0] OP_FIND         = 4'd9;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_INDEX = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

[rtl/bounded_ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: ordered list of up to DEPTH items in one RAM
// A sequencer applies one list operation per input transfer and returns one
// result transfer.
// ----------------------------------------------------------------------------
// The list lives in a single RAM with a registered read; position p of the
// list is RAM entry p-1. One operation is taken at a time. Errors and clear
// go from the input transfer straight to the finish step, which loads the
// output register. Peeks add a fetch step for the RAM read. Insert moves
// every item behind the insert point up by one entry, each move costing one
// read and one write of the RAM. Remove first fetches the removed item and
// then moves every item behind it down. Find reads one entry per cycle from
// the front until a match or the end of the list. A finished result sits in
// an output register; if that register is still full the sequencer waits for
// it, and the input is not ready again until the result has been loaded.
module bounded_ordered_list_engine #(
	parameter int DEPTH     = bole_pkg::DEPTH_DEF,
	parameter int ITEM_BITS = bole_pkg::ITEM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// operation[3:0], position[8:4], item_in[40:9], zero fill above
	input  logic [bole_pkg::S_DATA_W-1:0] s_tdata,
	// clear_all
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], item_out[33:2], found_position[38:34], count[43:39], zeros
	output logic [bole_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_FETCH    = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_UP       = 3'd3;
	localparam logic [2:0] S_UP_WR    = 3'd4;
	localparam logic [2:0] S_DN       = 3'd5;
	localparam logic [2:0] S_DN_WR    = 3'd6;
	localparam logic [2:0] S_FINISH   = 3'd7;

	// Input fields.
	logic [bole_pkg::OP_W-1:0]   op;
	logic [bole_pkg::POS_W-1:0]  pos;
	logic [bole_pkg::ITEM_W-1:0] item_in;

	assign op      = s_tdata[3:0];
	assign pos     = s_tdata[8:4];
	assign item_in = s_tdata[40:9];

	// Control state.
	logic [2:0]    st_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] k_q;
	logic          peek_q;
	logic          m_valid_q;

	// Per-operation payload.
	logic [ITEM_BITS-1:0]            item_q;
	logic [bole_pkg::STAT_W-1:0]     stat_q;
	logic [ITEM_BITS-1:0]            res_item_q;
	logic [CW-1:0]                   found_q;
	logic [bole_pkg::M_DATA_W-1:0]   m_data_q;

	// RAM ports.
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [ITEM_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [ITEM_BITS-1:0] rdata;

	bole_ram #(
		.WIDTH(ITEM_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic          accept;
	logic [PW-1:0] pos_x;
	logic [PW-1:0] occ_x;
	logic          empty;
	logic          full;
	logic          pos_bad;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] last_c;
	logic          out_free;

	// Decisions taken at the input transfer.
	logic [2:0]                  acc_st;
	logic [bole_pkg::STAT_W-1:0] acc_stat;
	logic [CW-1:0]               acc_k;
	logic [CW-1:0]               acc_cur;
	logic                        acc_peek;

	assign s_tready = (st_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign pos_x    = PW'(pos);
	assign occ_x    = PW'(occ_q);
	assign empty    = (occ_q == '0);
	assign full     = (occ_q == CW'(DEPTH));
	// Position outside 1..occupancy.
	assign pos_bad  = (pos_x == '0) || (pos_x > occ_x);
	assign pos_c    = CW'(pos_x);
	assign last_c   = occ_q - CW'(1);
	assign out_free = !m_valid_q || m_tready;

	// Status, next state and index registers for the operation being accepted.
	// A failed check goes straight to the finish step.
	always_comb begin
		acc_st   = S_FINISH;
		acc_stat = bole_pkg::ST_OK;
		acc_k    = '0;
		acc_cur  = occ_q;
		acc_peek = 1'b0;
		if (!s_tuser) begin
			case (op)
				bole_pkg::OP_ADD_FIRST: begin
					if (full) acc_stat = bole_pkg::ST_FULL;
					else      acc_st   = S_UP;
				end
				bole_pkg::OP_ADD_LAST: begin
					acc_k = occ_q;
					if (full) acc_stat = bole_pkg::ST_FULL;
					else      acc_st   = S_UP;
				end
				bole_pkg::OP_INSERT_AFTER: begin
					acc_k = pos_c;
					if (pos_x > occ_x)  acc_stat = bole_pkg::ST_INDEX;
					else if (full)      acc_stat = bole_pkg::ST_FULL;
					else                acc_st   = S_UP;
				end
				bole_pkg::OP_PEEK_FIRST,
				bole_pkg::OP_PEEK_LAST: begin
					acc_peek = 1'b1;
					if (empty) acc_stat = bole_pkg::ST_EMPTY;
					else       acc_st   = S_FETCH;
				end
				bole_pkg::OP_PEEK_AT: begin
					acc_peek = 1'b1;
					if (pos_bad) acc_stat = bole_pkg::ST_INDEX;
					else         acc_st   = S_FETCH;
				end
				bole_pkg::OP_REMOVE_FIRST: begin
					acc_cur = '0;
					if (empty) acc_stat = bole_pkg::ST_EMPTY;
					else       acc_st   = S_FETCH;
				end
				bole_pkg::OP_REMOVE_LAST: begin
					acc_cur = last_c;
					if (empty) acc_stat = bole_pkg::ST_EMPTY;
					else       acc_st   = S_FETCH;
				end
				bole_pkg::OP_REMOVE_AT: begin
					acc_cur = pos_c - CW'(1);
					if (empty)        acc_stat = bole_pkg::ST_EMPTY;
					else if (pos_bad) acc_stat = bole_pkg::ST_INDEX;
					else              acc_st   = S_FETCH;
				end
				bole_pkg::OP_FIND: begin
					acc_cur = '0;
					if (!empty) acc_st = S_SCAN;
				end
				default: ;
			endcase
		end
	end

	// RAM access is decided by the state and the index registers.
	always_comb begin
		we    = 1'b0;
		waddr = AW'(cur_q);
		wdata = rdata;
		raddr = AW'(cur_q);
		case (st_q)
			S_IDLE: begin
				case (op)
					bole_pkg::OP_PEEK_LAST,
					bole_pkg::OP_REMOVE_LAST: raddr = AW'(last_c);
					bole_pkg::OP_PEEK_AT,
					bole_pkg::OP_REMOVE_AT:   raddr = AW'(pos_c - CW'(1));
					default:                  raddr = '0;
				endcase
			end
			S_SCAN:  raddr = AW'(cur_q + CW'(1));
			S_UP: begin
				raddr = AW'(cur_q - CW'(1));
				if (cur_q <= k_q) begin
					we    = 1'b1;
					waddr = AW'(k_q);
					wdata = item_q;
				end
			end
			S_UP_WR: we = 1'b1;
			S_DN:    raddr = AW'(cur_q + CW'(1));
			S_DN_WR: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			occ_q     <= '0;
			cur_q     <= '0;
			k_q       <= '0;
			peek_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (st_q == S_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						st_q   <= acc_st;
						k_q    <= acc_k;
						cur_q  <= acc_cur;
						peek_q <= acc_peek;
						if (s_tuser) begin
							occ_q <= '0;
						end
					end
				end
				S_FETCH: st_q <= peek_q ? S_FINISH : S_DN;
				S_SCAN: begin
					if (rdata == item_q || cur_q + CW'(1) == occ_q) begin
						st_q <= S_FINISH;
					end else begin
						cur_q <= cur_q + CW'(1);
					end
				end
				S_UP: begin
					if (cur_q > k_q) begin
						st_q <= S_UP_WR;
					end else begin
						occ_q <= occ_q + CW'(1);
						st_q  <= S_FINISH;
					end
				end
				S_UP_WR: begin
					cur_q <= cur_q - CW'(1);
					st_q  <= S_UP;
				end
				S_DN: begin
					if (cur_q + CW'(1) < occ_q) begin
						st_q <= S_DN_WR;
					end else begin
						occ_q <= last_c;
						st_q  <= S_FINISH;
					end
				end
				S_DN_WR: begin
					cur_q <= cur_q + CW'(1);
					st_q  <= S_DN;
				end
				S_FINISH: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: status decided at the input transfer, item and
	// position filled in by the fetch and scan steps.
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					item_q     <= ITEM_BITS'(item_in);
					stat_q     <= acc_stat;
					res_item_q <= '0;
					found_q    <= '0;
				end
			end
			S_FETCH: res_item_q <= rdata;
			S_SCAN: begin
				if (rdata == item_q) found_q <= cur_q + CW'(1);
			end
			S_FINISH: begin
				if (out_free) begin
					m_data_q <= bole_pkg::M_DATA_W'({bole_pkg::CNT_W'(occ_q),
						bole_pkg::POS_W'(found_q), bole_pkg::ITEM_W'(res_item_q), stat_q});
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy exceeds depth");

	a_occ_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(occ_q) |-> ($past(st_q) == S_IDLE || $past(st_q) == S_UP ||
			$past(st_q) == S_DN))
		else $error("occupancy changed outside insert, remove or clear");

	a_dn_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DN_WR |-> (cur_q + CW'(1) < occ_q))
		else $error("down move beyond the list end");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (st_q == S_UP || st_q == S_UP_WR || st_q == S_DN_WR))
		else $error("RAM write outside a move");
`endif

endmodule

[rtl/bole_ram.sv]
// ----------------------------------------------------------------------------
// bole_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bole_ram #(
	parameter int WIDTH = bole_pkg::ITEM_BITS_DEF,
	parameter int DEPTH = bole_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sim/bounded_ordered_list_engine_test.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_test: self-checking bench for the list engine
// Drives list operations over the input stream, predicts each result with a
// behavioral copy of the list and compares every field of every result.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = bole_pkg::DEPTH_DEF;

	typedef struct packed {
		logic                        clear_all;
		logic [bole_pkg::ITEM_W-1:0] item_in;
		logic [bole_pkg::POS_W-1:0]  position;
		logic [bole_pkg::OP_W-1:0]   operation;
	} list_request_t;

	typedef struct packed {
		logic [bole_pkg::CNT_W-1:0]  count;
		logic [bole_pkg::POS_W-1:0]  found_position;
		logic [bole_pkg::ITEM_W-1:0] item_out;
		logic [bole_pkg::STAT_W-1:0] status;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [bole_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [bole_pkg::M_DATA_W-1:0] m_tdata;

	bounded_ordered_list_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the list; position p lives in shadow_list[p-1].
	logic [bole_pkg::ITEM_W-1:0] shadow_list [LIST_DEPTH];
	int unsigned shadow_count = 0;

	list_request_t pending_requests[$];
	list_reply_t   expected_replies[$];
	int error_count = 0;
	int send_idle_pct = 24;
	int recv_idle_pct = 72;

	// Transfer flag seen at the rising edge, used by the driver afterwards.
	logic s_tready_seen = 1'b0;

	// Applies one operation to the shadow list and returns the reply it causes.
	function automatic list_reply_t apply_list_op(list_request_t req);
		list_reply_t rep;
		int unsigned pos;
		int unsigned slot;
		rep = '0;
		pos = req.position;
		if (req.clear_all) begin
			shadow_count = 0;
		end else begin
			case (req.operation)
				bole_pkg::OP_ADD_FIRST, bole_pkg::OP_ADD_LAST,
				bole_pkg::OP_INSERT_AFTER: begin
					if (req.operation == bole_pkg::OP_INSERT_AFTER && pos > shadow_count) begin
						rep.status = bole_pkg::ST_INDEX;
					end else if (shadow_count >= LIST_DEPTH) begin
						rep.status = bole_pkg::ST_FULL;
					end else begin
						slot = (req.operation == bole_pkg::OP_ADD_FIRST) ? 0 :
							(req.operation == bole_pkg::OP_ADD_LAST) ? shadow_count : pos;
						for (int i = shadow_count; i > slot; i--)
							shadow_list[i] = shadow_list[i-1];
						shadow_list[slot] = req.item_in;
						shadow_count++;
					end
				end
				bole_pkg::OP_PEEK_FIRST, bole_pkg::OP_PEEK_LAST: begin
					if (shadow_count == 0)
						rep.status = bole_pkg::ST_EMPTY;
					else
						rep.item_out = shadow_list[(req.operation == bole_pkg::OP_PEEK_FIRST) ?
							0 : shadow_count-1];
				end
				bole_pkg::OP_PEEK_AT: begin
					if (pos < 1 || pos > shadow_count)
						rep.status = bole_pkg::ST_INDEX;
					else
						rep.item_out = shadow_list[pos-1];
				end
				bole_pkg::OP_REMOVE_FIRST, bole_pkg::OP_REMOVE_LAST,
				bole_pkg::OP_REMOVE_AT: begin
					if (shadow_count == 0) begin
						rep.status = bole_pkg::ST_EMPTY;
					end else if (req.operation == bole_pkg::OP_REMOVE_AT &&
							(pos < 1 || pos > shadow_count)) begin
						rep.status = bole_pkg::ST_INDEX;
					end else begin
						slot = (req.operation == bole_pkg::OP_REMOVE_FIRST) ? 0 :
							(req.operation == bole_pkg::OP_REMOVE_LAST) ? shadow_count-1 : pos-1;
						rep.item_out = shadow_list[slot];
						for (int i = slot; i + 1 < shadow_count; i++)
							shadow_list[i] = shadow_list[i+1];
						shadow_count--;
					end
				end
				bole_pkg::OP_FIND: begin
					for (int i = 0; i < shadow_count; i++) begin
						if (shadow_list[i] == req.item_in) begin
							rep.found_position = bole_pkg::POS_W'(i + 1);
							break;
						end
					end
				end
				default: ;
			endcase
		end
		rep.count = bole_pkg::CNT_W'(shadow_count);
		return rep;
	endfunction

	function automatic list_request_t make_request(logic [bole_pkg::OP_W-1:0] op,
			int unsigned pos, logic [bole_pkg::ITEM_W-1:0] value, logic clr);
		list_request_t req;
		req.operation = op;
		req.position  = bole_pkg::POS_W'(pos);
		req.item_in   = value;
		req.clear_all = clr;
		return req;
	endfunction

	// Random values mostly come from a small pool so that finds hit and
	// duplicates occur; the rest cover every bit of the item field.
	function automatic logic [bole_pkg::ITEM_W-1:0] random_item();
		if ($urandom_range(99) < 60)
			return $urandom_range(7);
		return $urandom;
	endfunction

	// Random operation biased toward filling or draining depending on a phase;
	// codes above the last defined operation and clears appear rarely.
	function automatic list_request_t random_request(bit filling);
		int unsigned pick;
		logic [bole_pkg::OP_W-1:0] op;
		pick = $urandom_range(99);
		if (pick < 2)
			return make_request(bole_pkg::OP_W'($urandom), $urandom, $urandom, 1'b1);
		if (pick < 5)
			op = bole_pkg::OP_W'($urandom_range(15, 10));
		else if (pick < (filling ? 55 : 25))
			op = bole_pkg::OP_W'($urandom_range(bole_pkg::OP_INSERT_AFTER,
				bole_pkg::OP_ADD_FIRST));
		else if (pick < 70)
			op = bole_pkg::OP_W'($urandom_range(bole_pkg::OP_REMOVE_AT,
				bole_pkg::OP_REMOVE_FIRST));
		else if (pick < 85)
			op = bole_pkg::OP_W'($urandom_range(bole_pkg::OP_PEEK_AT,
				bole_pkg::OP_PEEK_FIRST));
		else
			op = bole_pkg::OP_FIND;
		// Positions lean toward the valid range with an occasional full sweep.
		return make_request(op, ($urandom_range(9) == 0) ? $urandom : $urandom_range(17),
			random_item(), ($urandom_range(199) == 0) ? 1'b1 : 1'b0);
	endfunction

	// Driver: presents the queue head and moves on only after a transfer.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready_seen) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					list_request_t req;
					req = pending_requests.pop_front();
					s_tdata  <= {{(bole_pkg::S_DATA_W-bole_pkg::OP_W-bole_pkg::POS_W-
						bole_pkg::ITEM_W){1'b0}}, req.item_in, req.position, req.operation};
					s_tuser  <= req.clear_all;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts on each input transfer, checks on each output transfer.
	always @(posedge clk) begin
		s_tready_seen <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			list_request_t req;
			req.operation = s_tdata[bole_pkg::OP_W-1:0];
			req.position  = s_tdata[bole_pkg::OP_W+bole_pkg::POS_W-1:bole_pkg::OP_W];
			req.item_in   = s_tdata[bole_pkg::OP_W+bole_pkg::POS_W+bole_pkg::ITEM_W-1:
				bole_pkg::OP_W+bole_pkg::POS_W];
			req.clear_all = s_tuser;
			expected_replies.push_back(apply_list_op(req));
		end
		if (arst_n && m_tvalid && m_tready) begin
			list_reply_t got;
			list_reply_t want;
			got = m_tdata[$bits(list_reply_t)-1:0];
			if (expected_replies.size() == 0) begin
				$error("unexpected result transfer: %h", m_tdata);
				error_count++;
			end else begin
				want = expected_replies.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					error_count++;
				end
				if (got.item_out !== want.item_out) begin
					$error("item_out: expected %h, got %h", want.item_out, got.item_out);
					error_count++;
				end
				if (got.found_position !== want.found_position) begin
					$error("found_position: expected %0d, got %0d",
						want.found_position, got.found_position);
					error_count++;
				end
				if (got.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, got.count);
					error_count++;
				end
			end
		end
	end

	// The driver learns of a transfer from the flag registered at the rising edge,
	// so a sent item is only replaced once s_tready_seen confirms it; a held item stays put.

	// Watchdog: worst case is a full-list insert or remove per item with the
	// receiver stalling, far below this bound.
	int unsigned cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("bounded_ordered_list_engine_test: done, errors");
			$finish;
		end
	end

	task automatic wait_for_drain();
		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-list cases, fill to full, overflow, bad positions,
		// extreme values, find with a match, unused codes, clear.
		pending_requests.push_back(make_request(bole_pkg::OP_PEEK_FIRST, 0, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_PEEK_LAST, 0, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_PEEK_AT, 1, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_REMOVE_FIRST, 0, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_REMOVE_LAST, 0, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_REMOVE_AT, 0, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_INSERT_AFTER, 1, 5, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_ADD_FIRST, 0, 32'hFFFF_FFFF, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_REMOVE_FIRST, 0, 0, 0));
		for (int i = 0; i < 16; i++)
			pending_requests.push_back(make_request(bole_pkg::OP_ADD_LAST, 0,
				i * 32'h1111_1111, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_ADD_FIRST, 0, 1, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_INSERT_AFTER, 16, 1, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_INSERT_AFTER, 31, 1, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_PEEK_AT, 16, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_PEEK_AT, 0, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_REMOVE_AT, 17, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_FIND, 0, 32'hFFFF_FFFF, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_FIND, 0, 32'h3333_3333, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_REMOVE_AT, 16, 0, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_INSERT_AFTER, 0, 7, 0));
		pending_requests.push_back(make_request(4'd15, 31, 32'hFFFF_FFFF, 0));
		pending_requests.push_back(make_request(bole_pkg::OP_FIND, 0, 32'h0, 1));
		pending_requests.push_back(make_request(bole_pkg::OP_PEEK_LAST, 0, 0, 0));

		// Random part in three idling phases, alternating fill and drain bias
		// so the list swings between empty and full.
		for (int phase = 0; phase < 3; phase++) begin
			wait_for_drain();
			send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 72 : 0;
			recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 24 : 0;
			for (int i = 0; i < 120; i++)
				pending_requests.push_back(random_request(((i / 30) % 2) == 0));
		end
		wait_for_drain();
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("bounded_ordered_list_engine_test: done, clean");
		else
			$display("bounded_ordered_list_engine_test: done, errors");
		$finish;
	end

endmodule
